// ----- hdl/aidg_pkg.sv -----
package aidg_pkg;

	localparam int unsigned CFG_BITS = 16;
	localparam int unsigned COORD_BITS = 16;
	localparam int unsigned DIAG_BITS = 7;
	localparam int unsigned CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_FIRST = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LAST = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COL_FIRST = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COL_LAST = 2'd3;

	// Number of rows or columns spanned by first..last, clipped to max_side.
	// An inverted range gives an empty side.
	function automatic logic [CFG_BITS-1:0] side_len(
		input logic [CFG_BITS-1:0] first,
		input logic [CFG_BITS-1:0] last,
		input logic [CFG_BITS-1:0] max_side
	);
		logic [CFG_BITS-1:0] diff;
		logic [CFG_BITS-1:0] res;
		diff = last - first;
		if (last < first) begin
			res = '0;
		end else if (diff >= max_side) begin
			res = max_side;
		end else begin
			res = diff + CFG_BITS'(1);
		end
		return res;
	endfunction

endpackage

// ----- hdl/aidg_cfg.sv -----
module aidg_cfg #(
	parameter int unsigned MAX_SIDE = 64,
	parameter int unsigned SW = 7
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [aidg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [aidg_pkg::CFG_BITS-1:0]          cfg_data,
	output logic [aidg_pkg::CFG_BITS-1:0]          row_first,
	output logic [aidg_pkg::CFG_BITS-1:0]          col_first,
	output logic [SW-1:0]                          rows,
	output logic [SW-1:0]                          cols
);

	localparam int unsigned RESET_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;
	localparam logic [aidg_pkg::CFG_BITS-1:0] MAX_SIDE_C = aidg_pkg::CFG_BITS'(MAX_SIDE);

	logic [aidg_pkg::CFG_BITS-1:0] row_first_q;
	logic [aidg_pkg::CFG_BITS-1:0] row_last_q;
	logic [aidg_pkg::CFG_BITS-1:0] col_first_q;
	logic [aidg_pkg::CFG_BITS-1:0] col_last_q;
	logic [SW-1:0]                 rows_q;
	logic [SW-1:0]                 cols_q;
	logic [aidg_pkg::CFG_BITS-1:0] new_rows;
	logic [aidg_pkg::CFG_BITS-1:0] new_cols;

	assign cfg_ready = 1'b1;

	// The side lengths are updated on the same edge as the register write, so an
	// item may follow a write immediately.
	always_comb begin
		new_rows = aidg_pkg::side_len(row_first_q, row_last_q, MAX_SIDE_C);
		new_cols = aidg_pkg::side_len(col_first_q, col_last_q, MAX_SIDE_C);
		unique case (cfg_index)
			aidg_pkg::REG_ROW_FIRST: begin
				new_rows = aidg_pkg::side_len(cfg_data, row_last_q, MAX_SIDE_C);
			end
			aidg_pkg::REG_ROW_LAST: begin
				new_rows = aidg_pkg::side_len(row_first_q, cfg_data, MAX_SIDE_C);
			end
			aidg_pkg::REG_COL_FIRST: begin
				new_cols = aidg_pkg::side_len(cfg_data, col_last_q, MAX_SIDE_C);
			end
			aidg_pkg::REG_COL_LAST: begin
				new_cols = aidg_pkg::side_len(col_first_q, cfg_data, MAX_SIDE_C);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_first_q <= '0;
			row_last_q <= aidg_pkg::CFG_BITS'(63);
			col_first_q <= '0;
			col_last_q <= aidg_pkg::CFG_BITS'(63);
			rows_q <= SW'(RESET_SIDE);
			cols_q <= SW'(RESET_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aidg_pkg::REG_ROW_FIRST: row_first_q <= cfg_data;
				aidg_pkg::REG_ROW_LAST:  row_last_q <= cfg_data;
				aidg_pkg::REG_COL_FIRST: col_first_q <= cfg_data;
				aidg_pkg::REG_COL_LAST:  col_last_q <= cfg_data;
				default: begin
				end
			endcase
			rows_q <= new_rows[SW-1:0];
			cols_q <= new_cols[SW-1:0];
		end
	end

	assign row_first = row_first_q;
	assign col_first = col_first_q;
	assign rows = rows_q;
	assign cols = cols_q;

	a_rows_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= SW'(MAX_SIDE) && cols_q <= SW'(MAX_SIDE))
		else $error("box side exceeds the maximum");

endmodule

// ----- hdl/aidg_front.sv -----
module aidg_front #(
	parameter int unsigned SW = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [aidg_pkg::DIAG_BITS-1:0]    diag_number,
	input  logic                              mirrored,
	input  logic [SW-1:0]                     rows,
	input  logic [SW-1:0]                     cols,
	output logic                              push,
	output logic [3*SW:0]                     push_data,
	input  logic                              full
);

	localparam int unsigned CW = (SW > aidg_pkg::DIAG_BITS) ? SW : aidg_pkg::DIAG_BITS;

	logic [CW-1:0] k_w;
	logic [CW-1:0] m_w;
	logic [CW-1:0] n_w;
	logic [CW-1:0] mm1_w;
	logic [CW-1:0] srow_w;
	logic [CW-1:0] scol_w;
	logic [CW-1:0] nrem_w;
	logic [CW-1:0] len_w;
	logic          past;
	logic          empty;

	always_comb begin
		k_w = CW'(diag_number);
		m_w = CW'(rows);
		n_w = CW'(cols);
		mm1_w = m_w - CW'(1);
		past = k_w > mm1_w;
		srow_w = past ? mm1_w : k_w;
		scol_w = past ? (k_w - mm1_w) : '0;
		// A diagonal past the end of the box, or an empty box, yields no cells.
		empty = (rows == '0) || (cols == '0) || (scol_w >= n_w);
		nrem_w = n_w - scol_w;
		len_w = (nrem_w < (srow_w + CW'(1))) ? nrem_w : (srow_w + CW'(1));
	end

	assign item_stall = full;
	assign push = item_valid && !full && !empty;
	assign push_data = {mirrored, srow_w[SW-1:0], scol_w[SW-1:0], len_w[SW-1:0]};

	a_push_len: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (len_w != '0) && (len_w <= m_w))
		else $error("queued diagonal has an impossible length");

endmodule

// ----- hdl/aidg_fifo.sv -----
module aidg_fifo #(
	parameter int unsigned WIDTH = 22,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

// ----- hdl/aidg_back.sv -----
module aidg_back #(
	parameter int unsigned SW = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              empty,
	input  logic [3*SW:0]                     pop_data,
	output logic                              pop,
	input  logic [aidg_pkg::CFG_BITS-1:0]     row_first,
	input  logic [aidg_pkg::CFG_BITS-1:0]     col_first,
	input  logic [SW-1:0]                     rows,
	input  logic [SW-1:0]                     cols,
	output logic                              cell_valid,
	input  logic                              cell_stall,
	output logic [aidg_pkg::COORD_BITS-1:0]   row_index,
	output logic [aidg_pkg::COORD_BITS-1:0]   col_index,
	output logic                              final_cell
);

	logic          active_q;
	logic          mir_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] r_q;
	logic [SW-1:0] c_q;
	logic          cell_valid_q;
	logic [aidg_pkg::COORD_BITS-1:0] row_index_q;
	logic [aidg_pkg::COORD_BITS-1:0] col_index_q;
	logic          final_cell_q;

	logic          ent_mir;
	logic [SW-1:0] ent_srow;
	logic [SW-1:0] ent_scol;
	logic [SW-1:0] ent_len;
	logic          advance;
	logic          last_step;

	assign {ent_mir, ent_srow, ent_scol, ent_len} = pop_data;

	assign pop = !active_q && !empty;
	assign advance = active_q && (!cell_valid_q || !cell_stall);
	assign last_step = (rem_q == SW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cell_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (advance && last_step) begin
				active_q <= 1'b0;
			end
			if (advance) begin
				cell_valid_q <= 1'b1;
			end else if (!cell_stall) begin
				cell_valid_q <= 1'b0;
			end
		end
	end

	// Cell position inside the box. A mirrored run walks the diagonal from the
	// opposite corner, so its row climbs and its column falls.
	always_ff @(posedge clk) begin
		if (pop) begin
			mir_q <= ent_mir;
			rem_q <= ent_len;
			r_q <= ent_mir ? (rows - SW'(1) - ent_srow) : ent_srow;
			c_q <= ent_mir ? (cols - SW'(1) - ent_scol) : ent_scol;
		end else if (advance) begin
			rem_q <= rem_q - SW'(1);
			r_q <= mir_q ? (r_q + SW'(1)) : (r_q - SW'(1));
			c_q <= mir_q ? (c_q - SW'(1)) : (c_q + SW'(1));
		end
		if (advance) begin
			row_index_q <= row_first + aidg_pkg::COORD_BITS'(r_q);
			col_index_q <= col_first + aidg_pkg::COORD_BITS'(c_q);
			final_cell_q <= last_step;
		end
	end

	assign cell_valid = cell_valid_q;
	assign row_index = row_index_q;
	assign col_index = col_index_q;
	assign final_cell = final_cell_q;

	a_active_has_cells: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rem_q != '0)
		else $error("run active with no cells left");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_step |=> !active_q && cell_valid && final_cell)
		else $error("last cell did not close the run");

endmodule

// ----- hdl/antidiagonal_index_generator_unit.sv -----
// Anti-diagonal index generator.
// An item (diag_number, mirrored) enters on the item channel when item_valid
// is high and item_stall is low. For each item the block sends the cells of
// that anti-diagonal of the configured box on the cell channel, one
// transaction per cell, with final_cell set on the last one. A diagonal that
// lies outside the box, or an empty box, produces no cells.
// The box is set through the cfg channel (index 0..3: row first, row last,
// column first, column last); cfg_ready is always high, and a write may be
// followed by an item on the next cycle. Write only while the block is idle.
// An accepted item is written into the queue, then loaded into the run
// registers, and its first cell is registered in the output register. The
// cell generator loads each run, then sends one cell per cycle while the
// receiver does not stall. A two-entry queue sits in front of the generator,
// so items are taken while a run is still being sent; item_stall rises when
// it is full. When the receiver stalls, the current cell holds in the output
// register and the run pauses. Reset loads the box to 64 by 64 at the origin
// (clipped to MAX_SIDE) and empties the queue and the output register.
module antidiagonal_index_generator_unit #(
	parameter int unsigned MAX_SIDE = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aidg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [aidg_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [aidg_pkg::DIAG_BITS-1:0]      diag_number,
	input  logic                                mirrored,
	output logic                                cell_valid,
	input  logic                                cell_stall,
	output logic [aidg_pkg::COORD_BITS-1:0]     row_index,
	output logic [aidg_pkg::COORD_BITS-1:0]     col_index,
	output logic                                final_cell
);

	localparam int unsigned SW = $clog2(MAX_SIDE + 1);
	localparam int unsigned EW = 3 * SW + 1;
	localparam int unsigned QUEUE_DEPTH = 2;

	logic [aidg_pkg::CFG_BITS-1:0] row_first;
	logic [aidg_pkg::CFG_BITS-1:0] col_first;
	logic [SW-1:0]                 rows;
	logic [SW-1:0]                 cols;
	logic                          push;
	logic [EW-1:0]                 push_data;
	logic                          full;
	logic                          pop;
	logic [EW-1:0]                 pop_data;
	logic                          empty;

	aidg_cfg #(
		.MAX_SIDE(MAX_SIDE),
		.SW(SW)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.row_first(row_first),
		.col_first(col_first),
		.rows(rows),
		.cols(cols)
	);

	aidg_front #(
		.SW(SW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.diag_number(diag_number),
		.mirrored(mirrored),
		.rows(rows),
		.cols(cols),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	aidg_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	aidg_back #(
		.SW(SW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.pop_data(pop_data),
		.pop(pop),
		.row_first(row_first),
		.col_first(col_first),
		.rows(rows),
		.cols(cols),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.row_index(row_index),
		.col_index(col_index),
		.final_cell(final_cell)
	);

endmodule
